FILE: hw/rtl/kdr_pkg.sv
package kdr_pkg;

    localparam int ROW_COUNT   = 4;
    localparam int COL_COUNT   = 3;
    localparam int KEY_COUNT   = ROW_COUNT * COL_COUNT;
    localparam int KEY_IDX_W   = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    localparam int MASK_BITS   = 12;
    localparam int MAP_SIZE    = 12;
    localparam int TIME_W      = 32;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int KEY_INDEX_W = 4;
    localparam int CODE_W      = 8;

    localparam logic [CODE_W-1:0] REPEAT_FLAG = 8'h80;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT   = 2'd2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd20;
    localparam logic [CFG_W-1:0] HOLD_RESET     = 16'd500;
    localparam logic [CFG_W-1:0] REPEAT_RESET   = 16'd100;

    typedef enum logic [1:0] {
        EVT_NONE   = 2'd0,
        EVT_PRESS  = 2'd1,
        EVT_REPEAT = 2'd2
    } evt_kind_t;

    typedef struct packed {
        logic              raw_last;
        logic              stable_pressed;
        logic              hold_done;
        logic [TIME_W-1:0] change_stamp;
        logic [TIME_W-1:0] press_stamp;
        logic [TIME_W-1:0] repeat_stamp;
    } key_state_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_time;
        logic [CFG_W-1:0] hold_time;
        logic [CFG_W-1:0] repeat_time;
    } cfg_t;

    typedef struct packed {
        logic                 hit;
        evt_kind_t            kind;
        logic [KEY_IDX_W-1:0] index;
    } pick_t;

    // ASCII character printed on each key, row by row
    function automatic logic [CODE_W-1:0] code_of(input logic [KEY_IDX_W-1:0] k);
        logic [CODE_W-1:0] c;
        unique case (int'(k))
            0:       c = 8'h31;
            1:       c = 8'h32;
            2:       c = 8'h33;
            3:       c = 8'h34;
            4:       c = 8'h35;
            5:       c = 8'h36;
            6:       c = 8'h37;
            7:       c = 8'h38;
            8:       c = 8'h39;
            9:       c = 8'h2A;
            10:      c = 8'h30;
            11:      c = 8'h23;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/kdr_lane.sv
module kdr_lane (
    input  logic                      raw,
    input  logic [31:0]               now,
    input  kdr_pkg::cfg_t             cfg,
    input  kdr_pkg::key_state_t       cur,
    output kdr_pkg::key_state_t       nxt,
    output kdr_pkg::evt_kind_t        evt
);
    import kdr_pkg::*;

    logic [TIME_W-1:0] chg_stamp;
    logic [TIME_W-1:0] age_chg;
    logic [TIME_W-1:0] age_press;
    logic [TIME_W-1:0] age_rep;

    // restart the debounce window on any raw edge
    assign chg_stamp = (raw != cur.raw_last) ? now : cur.change_stamp;
    assign age_chg   = now - chg_stamp;
    assign age_press = now - cur.press_stamp;
    assign age_rep   = now - cur.repeat_stamp;

    always_comb begin
        nxt              = cur;
        evt              = EVT_NONE;
        nxt.raw_last     = raw;
        nxt.change_stamp = chg_stamp;
        if (age_chg >= TIME_W'(cfg.debounce_time)) begin
            if (raw != cur.stable_pressed) begin
                nxt.stable_pressed = raw;
                if (raw) begin
                    nxt.press_stamp = now;
                    nxt.hold_done   = 1'b0;
                    evt             = EVT_PRESS;
                end
            end else if (raw) begin
                if (!cur.hold_done && age_press >= TIME_W'(cfg.hold_time)) begin
                    nxt.hold_done    = 1'b1;
                    nxt.repeat_stamp = now;
                    evt              = EVT_REPEAT;
                end else if (cur.hold_done && age_rep >= TIME_W'(cfg.repeat_time)) begin
                    nxt.repeat_stamp = now;
                    evt              = EVT_REPEAT;
                end
            end
        end
    end

endmodule

FILE: hw/rtl/kdr_merge.sv
module kdr_merge (
    input  kdr_pkg::evt_kind_t             evt [kdr_pkg::KEY_COUNT],
    output logic [kdr_pkg::KEY_COUNT-1:0]  commit,
    output kdr_pkg::pick_t                 pick
);
    import kdr_pkg::*;

    // first key with an event wins; keys after it keep their old state
    always_comb begin
        logic found;
        found  = 1'b0;
        pick   = '0;
        commit = '0;
        for (int k = 0; k < KEY_COUNT; k++) begin
            commit[k] = !found;
            if (!found && evt[k] != EVT_NONE) begin
                pick.hit   = 1'b1;
                pick.kind  = evt[k];
                pick.index = KEY_IDX_W'(k);
                found      = 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/keypad_debounce_repeat.sv
// Channel  Direction  Handshake          Payload
// s_       in         s_valid / s_ready  s_tick_time[31:0], s_pressed_mask[11:0]
// m_       out        m_valid / m_ready  m_event_kind[1:0], m_key_index[3:0], m_key_code[7:0]
// cfg_     in         cfg_wr_en          cfg_wr_index[1:0], cfg_wr_data[15:0]
//
// One request per cycle while the output is not stalled: all key lanes evaluate a
// scan at once and the priority merge picks the lowest key with an event, and the
// result is registered on acceptance.
// Reset (aresetn low, synchronous) clears all key state and the output valid,
// and loads debounce 20, hold 500, repeat 100.
// A held output stalls input only when the result register is full and not taken.
module keypad_debounce_repeat (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [kdr_pkg::TIME_W-1:0]      s_tick_time,
    input  logic [kdr_pkg::MASK_BITS-1:0]   s_pressed_mask,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_event_kind,
    output logic [kdr_pkg::KEY_INDEX_W-1:0] m_key_index,
    output logic [kdr_pkg::CODE_W-1:0]      m_key_code,

    input  logic                            cfg_wr_en,
    input  logic [kdr_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [kdr_pkg::CFG_W-1:0]       cfg_wr_data
);
    import kdr_pkg::*;

    cfg_t       cfg_reg;
    key_state_t key_state_reg  [KEY_COUNT];
    key_state_t key_state_next [KEY_COUNT];
    evt_kind_t  lane_evt       [KEY_COUNT];

    logic [KEY_COUNT-1:0]   commit;
    pick_t                  pick;
    logic                   accept;

    logic                   m_valid_reg;
    evt_kind_t              event_kind_reg;
    logic [KEY_INDEX_W-1:0] key_index_reg;
    logic [CODE_W-1:0]      key_code_reg;
    logic [CODE_W-1:0]      key_code_next;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    for (genvar k = 0; k < KEY_COUNT; k++) begin : g_lane
        logic raw;
        if (k < MASK_BITS) begin : g_in_mask
            assign raw = s_pressed_mask[k];
        end else begin : g_no_mask
            assign raw = 1'b0;
        end

        kdr_lane u_lane (
            .raw (raw),
            .now (s_tick_time),
            .cfg (cfg_reg),
            .cur (key_state_reg[k]),
            .nxt (key_state_next[k]),
            .evt (lane_evt[k])
        );
    end

    kdr_merge u_merge (
        .evt    (lane_evt),
        .commit (commit),
        .pick   (pick)
    );

    assign key_code_next = pick.hit
        ? (code_of(pick.index) | ((pick.kind == EVT_REPEAT) ? REPEAT_FLAG : '0))
        : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_time <= DEBOUNCE_RESET;
            cfg_reg.hold_time     <= HOLD_RESET;
            cfg_reg.repeat_time   <= REPEAT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_DEBOUNCE: cfg_reg.debounce_time <= cfg_wr_data;
                CFG_HOLD:     cfg_reg.hold_time     <= cfg_wr_data;
                CFG_REPEAT:   cfg_reg.repeat_time   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
                key_state_reg[k] <= '0;
            end
        end else if (accept) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
                if (commit[k]) begin
                    key_state_reg[k] <= key_state_next[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            event_kind_reg <= pick.kind;
            key_index_reg  <= KEY_INDEX_W'(pick.index);
            key_code_reg   <= key_code_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_event_kind = event_kind_reg;
    assign m_key_index  = key_index_reg;
    assign m_key_code   = key_code_reg;

`ifndef SYNTHESIS
    a_none_is_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind == EVT_NONE |-> m_key_index == '0 && m_key_code == '0)
        else $error("no-event result carries a key");

    a_repeat_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind == EVT_REPEAT |-> m_key_code[CODE_W-1])
        else $error("hold or repeat result without repeat flag");

    a_press_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind == EVT_PRESS |-> !m_key_code[CODE_W-1])
        else $error("press result with repeat flag");

    a_commit_all: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !pick.hit |-> &commit)
        else $error("scan without event left keys uncommitted");
`endif

endmodule
